@@ hw/rtl/binary_heap_priority_queue_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the binary heap priority queue
// Shared property forms, clocked on clk and held off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef BINARY_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BHPQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("heap queue check failed");

// The consequent must hold in the cycle after the antecedent.
`define BHPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("heap queue check failed");

`endif

@@ hw/rtl/bhpq_pkg.sv @@
// ---------------------------------------------------------------------------
// bhpq_pkg
// Sizes, codes, shared types and compare helpers of the heap queue.
// ---------------------------------------------------------------------------
`default_nettype none

package bhpq_pkg;

  localparam int CAPACITY   = 64;
  localparam int KEY_W      = 32;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int ST_W       = 2;
  // One cell per tree level; slot s sits on level floor(log2 s).
  localparam int LEVELS     = CNT_W;
  localparam int LW         = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PW         = (LEVELS > 2) ? LEVELS - 1 : 2;
  localparam int AW         = PW - 1;
  localparam int SW         = CNT_W + 1;
  localparam int BANK_DEPTH = 1 << AW;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic ORDER_MAX = 1'b0;
  localparam logic ORDER_MIN = 1'b1;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [LW-1:0]           lvl_t;
  typedef logic [PW-1:0]           pos_t;
  typedef logic [AW-1:0]           addr_t;
  typedef logic [ST_W-1:0]         status_t;

  // The key being sifted and its place within the level of the cell holding it.
  typedef struct packed {
    logic vld;
    logic up;
    key_t key;
    pos_t pos;
  } tok_t;

  // A level is stored as even and odd banks, so both children come in one read.
  typedef struct packed {
    key_t odd;
    key_t even;
  } pair_t;

  // Read request a cell raises toward the neighbor above (up) or below.
  typedef struct packed {
    logic  vld;
    logic  up;
    addr_t addr;
  } rd_req_t;

  typedef struct packed {
    logic  vld;
    addr_t addr;
  } rd_port_t;

  // Root and last-slot fetch raised by the controller for a remove.
  typedef struct packed {
    logic  vld;
    lvl_t  lvl;
    addr_t addr;
  } ctrl_rd_t;

  typedef struct packed {
    logic order;
    cnt_t count;
  } ctx_t;

  // True when key a belongs strictly above key b in the given order.
  function automatic logic ranks_above(input key_t a, input key_t b, input logic order);
    return (order == ORDER_MIN) ? (a < b) : (a > b);
  endfunction

  function automatic lvl_t slot_level(input cnt_t s);
    lvl_t l;
    l = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (s[i]) begin
        l = LW'(i);
      end
    end
    return l;
  endfunction

  function automatic pos_t slot_index(input cnt_t s);
    cnt_t m;
    m = s & ~(cnt_t'(1) << slot_level(s));
    return pos_t'(m);
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bhpq_req_if.sv @@
// ---------------------------------------------------------------------------
// bhpq_req_if
// Request channel: one word is an operation code and a key.
// ---------------------------------------------------------------------------
`default_nettype none

interface bhpq_req_if;
  logic            valid;
  logic            ready;
  logic            operation;
  bhpq_pkg::key_t  key;

  modport source (output valid, output operation, output key, input ready);
  modport sink   (input valid, input operation, input key, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bhpq_res_if.sv @@
// ---------------------------------------------------------------------------
// bhpq_res_if
// Result channel: one word is a status, the removed key and the key count.
// ---------------------------------------------------------------------------
`default_nettype none

interface bhpq_res_if;
  logic               valid;
  logic               ready;
  bhpq_pkg::status_t  status;
  bhpq_pkg::key_t     removed_key;
  bhpq_pkg::cnt_t     element_count;

  modport source (output valid, output status, output removed_key, output element_count,
                  input ready);
  modport sink   (input valid, input status, input removed_key, input element_count,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bhpq_cell.sv @@
// ---------------------------------------------------------------------------
// bhpq_cell
// One tree level: its slots in two banks and one step of sift up or down.
// ---------------------------------------------------------------------------
`default_nettype none

module bhpq_cell (
  input  wire                  clk,
  input  wire                  rst_n,
  input  bhpq_pkg::lvl_t       lvl,
  input  bhpq_pkg::ctx_t       ctx,
  input  bhpq_pkg::tok_t       tok_in,
  input  bhpq_pkg::pair_t      child_pair,
  input  bhpq_pkg::pair_t      parent_pair,
  input  bhpq_pkg::rd_port_t   rd_in,
  output bhpq_pkg::tok_t       tok_dn,
  output bhpq_pkg::tok_t       tok_up,
  output bhpq_pkg::rd_req_t    rd_req,
  output bhpq_pkg::pair_t      rd_pair,
  output logic                 done
);

  localparam logic PH_ISSUE  = 1'b0;
  localparam logic PH_DECIDE = 1'b1;

  bhpq_pkg::tok_t   tok_r, tok_nxt;
  logic             ph_r, ph_nxt;
  bhpq_pkg::key_t   mem_even [bhpq_pkg::BANK_DEPTH];
  bhpq_pkg::key_t   mem_odd  [bhpq_pkg::BANK_DEPTH];
  bhpq_pkg::pair_t  rd_pair_r;

  logic [bhpq_pkg::SW-1:0] slot, left_slot, right_slot, count_ext;
  logic                    has_left, has_right, use_right, dn_swap, up_swap, wr_en;
  bhpq_pkg::key_t          best_key, parent_key, wr_data;
  bhpq_pkg::addr_t         wr_addr;

  assign slot       = (bhpq_pkg::SW'(1) << lvl) | bhpq_pkg::SW'(tok_r.pos);
  assign left_slot  = {slot[bhpq_pkg::SW-2:0], 1'b0};
  assign right_slot = {slot[bhpq_pkg::SW-2:0], 1'b1};
  assign count_ext  = bhpq_pkg::SW'(ctx.count);
  assign has_left   = left_slot <= count_ext;
  assign has_right  = right_slot <= count_ext;

  // The left child wins a tie; a right child past the count is never looked at.
  assign use_right  = has_right &&
                      bhpq_pkg::ranks_above(child_pair.odd, child_pair.even, ctx.order);
  assign best_key   = use_right ? child_pair.odd : child_pair.even;
  assign dn_swap    = bhpq_pkg::ranks_above(best_key, tok_r.key, ctx.order);
  assign parent_key = tok_r.pos[1] ? parent_pair.odd : parent_pair.even;
  assign up_swap    = bhpq_pkg::ranks_above(tok_r.key, parent_key, ctx.order);
  assign wr_addr    = tok_r.pos[bhpq_pkg::PW-1:1];

  always_comb begin
    tok_nxt = tok_r;
    ph_nxt  = ph_r;
    tok_dn  = '0;
    tok_up  = '0;
    rd_req  = '0;
    wr_en   = 1'b0;
    wr_data = tok_r.key;
    done    = 1'b0;
    if (tok_in.vld) begin
      tok_nxt = tok_in;
      ph_nxt  = PH_ISSUE;
    end else if (tok_r.vld) begin
      if (ph_r == PH_ISSUE) begin
        if (tok_r.up ? (lvl == '0) : !has_left) begin
          wr_en       = 1'b1;
          done        = 1'b1;
          tok_nxt.vld = 1'b0;
        end else begin
          rd_req.vld  = 1'b1;
          rd_req.up   = tok_r.up;
          rd_req.addr = tok_r.up ? bhpq_pkg::addr_t'(tok_r.pos >> 2)
                                 : tok_r.pos[bhpq_pkg::AW-1:0];
          ph_nxt      = PH_DECIDE;
        end
      end else begin
        wr_en       = 1'b1;
        tok_nxt.vld = 1'b0;
        if (tok_r.up) begin
          if (up_swap) begin
            wr_data    = parent_key;
            tok_up.vld = 1'b1;
            tok_up.up  = 1'b1;
            tok_up.key = tok_r.key;
            tok_up.pos = tok_r.pos >> 1;
          end else begin
            done = 1'b1;
          end
        end else begin
          if (dn_swap) begin
            wr_data    = best_key;
            tok_dn.vld = 1'b1;
            tok_dn.up  = 1'b0;
            tok_dn.key = tok_r.key;
            tok_dn.pos = {tok_r.pos[bhpq_pkg::AW-1:0], use_right};
          end else begin
            done = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
      ph_r  <= PH_ISSUE;
    end else begin
      tok_r <= tok_nxt;
      ph_r  <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (tok_r.pos[0]) begin
        mem_odd[wr_addr] <= wr_data;
      end else begin
        mem_even[wr_addr] <= wr_data;
      end
    end
    if (rd_in.vld) begin
      rd_pair_r.even <= mem_even[rd_in.addr];
      rd_pair_r.odd  <= mem_odd[rd_in.addr];
    end
  end

  assign rd_pair = rd_pair_r;

endmodule

`default_nettype wire

@@ hw/rtl/bhpq_ctrl.sv @@
// ---------------------------------------------------------------------------
// bhpq_ctrl
// Takes requests, keeps the key count and order, starts sifts, sends results.
// ---------------------------------------------------------------------------
`default_nettype none

module bhpq_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_we,
  input  wire                  cfg_wdata,
  bhpq_req_if.sink             in_chan,
  bhpq_res_if.source           out_chan,
  input  bhpq_pkg::pair_t      cell_pair [bhpq_pkg::LEVELS],
  input  wire                  sift_done,
  output bhpq_pkg::ctx_t       ctx,
  output bhpq_pkg::tok_t       inj,
  output bhpq_pkg::lvl_t       inj_lvl,
  output bhpq_pkg::ctrl_rd_t   crd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_SIFT  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]          st_r, st_nxt;
  bhpq_pkg::cnt_t      cnt_r, cnt_nxt, new_slot;
  logic                order_r, order_nxt;
  bhpq_pkg::tok_t      inj_r, inj_nxt;
  bhpq_pkg::lvl_t      inj_lvl_r, inj_lvl_nxt;
  bhpq_pkg::lvl_t      last_lvl_r, last_lvl_nxt;
  bhpq_pkg::pos_t      last_idx_r, last_idx_nxt;
  bhpq_pkg::status_t   res_status_r, res_status_nxt;
  bhpq_pkg::key_t      res_key_r, res_key_nxt, last_key;
  logic                out_vld_r, out_vld_nxt;
  bhpq_pkg::status_t   out_status_r, out_status_nxt;
  bhpq_pkg::key_t      out_key_r, out_key_nxt;
  bhpq_pkg::cnt_t      out_cnt_r, out_cnt_nxt;
  bhpq_pkg::pair_t     last_pair;
  logic                accept;

  assign in_chan.ready = (st_r == S_IDLE);
  assign accept        = in_chan.valid && (st_r == S_IDLE);
  assign new_slot      = cnt_r + bhpq_pkg::cnt_t'(1);
  assign last_pair     = cell_pair[last_lvl_r];
  assign last_key      = last_idx_r[0] ? last_pair.odd : last_pair.even;

  always_comb begin
    st_nxt         = st_r;
    cnt_nxt        = cnt_r;
    order_nxt      = cfg_we ? cfg_wdata : order_r;
    inj_nxt        = inj_r;
    inj_nxt.vld    = 1'b0;
    inj_lvl_nxt    = inj_lvl_r;
    last_lvl_nxt   = last_lvl_r;
    last_idx_nxt   = last_idx_r;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;
    out_vld_nxt    = out_vld_r && !out_chan.ready;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_cnt_nxt    = out_cnt_r;
    unique case (st_r)
      S_IDLE: begin
        if (accept) begin
          res_key_nxt    = '0;
          res_status_nxt = bhpq_pkg::ST_OK;
          if (in_chan.operation == bhpq_pkg::OP_INSERT) begin
            if (cnt_r == bhpq_pkg::cnt_t'(bhpq_pkg::CAPACITY)) begin
              res_status_nxt = bhpq_pkg::ST_FULL;
              st_nxt         = S_DONE;
            end else begin
              cnt_nxt     = new_slot;
              inj_nxt.vld = 1'b1;
              inj_nxt.up  = 1'b1;
              inj_nxt.key = in_chan.key;
              inj_nxt.pos = bhpq_pkg::slot_index(new_slot);
              inj_lvl_nxt = bhpq_pkg::slot_level(new_slot);
              st_nxt      = S_SIFT;
            end
          end else begin
            if (cnt_r == '0) begin
              res_status_nxt = bhpq_pkg::ST_EMPTY;
              st_nxt         = S_DONE;
            end else begin
              cnt_nxt      = cnt_r - bhpq_pkg::cnt_t'(1);
              last_lvl_nxt = bhpq_pkg::slot_level(cnt_r);
              last_idx_nxt = bhpq_pkg::slot_index(cnt_r);
              st_nxt       = S_READ;
            end
          end
        end
      end
      S_READ: begin
        st_nxt = S_FETCH;
      end
      S_FETCH: begin
        res_key_nxt = cell_pair[0].even;
        inj_nxt.vld = 1'b1;
        inj_nxt.up  = 1'b0;
        inj_nxt.key = last_key;
        inj_nxt.pos = '0;
        inj_lvl_nxt = '0;
        st_nxt      = S_SIFT;
      end
      S_SIFT: begin
        if (sift_done) begin
          st_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_vld_r || out_chan.ready) begin
          out_vld_nxt    = 1'b1;
          out_status_nxt = res_status_r;
          out_key_nxt    = res_key_r;
          out_cnt_nxt    = cnt_r;
          st_nxt         = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      cnt_r     <= '0;
      order_r   <= bhpq_pkg::ORDER_MAX;
      inj_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      cnt_r     <= cnt_nxt;
      order_r   <= order_nxt;
      inj_r     <= inj_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    inj_lvl_r    <= inj_lvl_nxt;
    last_lvl_r   <= last_lvl_nxt;
    last_idx_r   <= last_idx_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign ctx.order = order_r;
  assign ctx.count = cnt_r;
  assign inj       = inj_r;
  assign inj_lvl   = inj_lvl_r;
  assign crd.vld   = (st_r == S_READ);
  assign crd.lvl   = last_lvl_r;
  assign crd.addr  = last_idx_r[bhpq_pkg::PW-1:1];

  assign out_chan.valid         = out_vld_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.removed_key   = out_key_r;
  assign out_chan.element_count = out_cnt_r;

endmodule

`default_nettype wire

@@ hw/rtl/binary_heap_priority_queue.sv @@
// ---------------------------------------------------------------------------
// binary_heap_priority_queue
// Binary heap of signed 32-bit keys, built as a chain of one cell per level.
// ---------------------------------------------------------------------------
// The queue holds up to 64 signed keys and answers every request word with
// exactly one result word. An insert places the key in the first free slot
// and sifts it toward the root; a remove returns the top key, moves the last
// key to the root and sifts it down, taking the left child when both children
// are equal. Inserting into a full heap drops the key with status full, and
// removing from an empty heap returns status empty and a zero key. Writing
// cfg_wdata with cfg_we high selects the order: 0 puts the largest key on
// top, 1 the smallest; keys already held are not reordered. The queue works
// on one request at a time. For each level that a key moves, the cell first
// makes a registered read of the neighboring cell's slot pair and then
// compares and writes back; a remove first fetches the root and the last
// key. With 64 keys a key moves at most six levels. A finished result sits
// in an output register, so the next request is accepted while the result
// still waits to be taken. The store has no reset and needs none: only
// slots up to the key count are ever used.
// ---------------------------------------------------------------------------
`default_nettype none

module binary_heap_priority_queue (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          cfg_we,
  input  wire          cfg_wdata,
  bhpq_req_if.sink     in_chan,
  bhpq_res_if.source   out_chan
);

  localparam int L = bhpq_pkg::LEVELS;

  bhpq_pkg::ctx_t      ctx;
  bhpq_pkg::tok_t      inj;
  bhpq_pkg::lvl_t      inj_lvl;
  bhpq_pkg::ctrl_rd_t  crd;

  // Per-level wiring: a level talks to the level above and the level below.
  bhpq_pkg::pair_t     cell_pair [L];
  bhpq_pkg::tok_t      tok_dn    [L];
  bhpq_pkg::tok_t      tok_up    [L];
  bhpq_pkg::tok_t      tok_in    [L];
  bhpq_pkg::rd_req_t   cell_rd   [L];
  bhpq_pkg::rd_port_t  rd_in     [L];
  logic [L-1:0]        cell_done;
  logic                sift_done;

  assign sift_done = |cell_done;

  bhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cell_pair (cell_pair),
    .sift_done (sift_done),
    .ctx       (ctx),
    .inj       (inj),
    .inj_lvl   (inj_lvl),
    .crd       (crd)
  );

  for (genvar k = 0; k < L; k++) begin : g_level
    bhpq_pkg::tok_t     tok_a, tok_b;
    bhpq_pkg::rd_req_t  req_a, req_b;
    bhpq_pkg::pair_t    par_p, chi_p;
    logic               inj_hit, a_hit, b_hit, c_hit, c_last;

    // Level zero has no parent and the deepest level has no children.
    if (k == 0) begin : g_top
      assign tok_a = '0;
      assign req_a = '0;
      assign par_p = '0;
    end else begin : g_mid_top
      assign tok_a = tok_dn[k-1];
      assign req_a = cell_rd[k-1];
      assign par_p = cell_pair[k-1];
    end

    if (k == L - 1) begin : g_bottom
      assign tok_b = '0;
      assign req_b = '0;
      assign chi_p = '0;
    end else begin : g_mid_bottom
      assign tok_b = tok_up[k+1];
      assign req_b = cell_rd[k+1];
      assign chi_p = cell_pair[k+1];
    end

    // Only one key is being sifted at a time, so at most one source is live.
    always_comb begin
      inj_hit = inj.vld && (inj_lvl == bhpq_pkg::LW'(k));
      a_hit   = req_a.vld && !req_a.up;
      b_hit   = req_b.vld && req_b.up;
      c_last  = crd.vld && (crd.lvl == bhpq_pkg::LW'(k));
      c_hit   = crd.vld && ((k == 0) || c_last);
      if (tok_a.vld) begin
        tok_in[k] = tok_a;
      end else if (tok_b.vld) begin
        tok_in[k] = tok_b;
      end else if (inj_hit) begin
        tok_in[k] = inj;
      end else begin
        tok_in[k] = '0;
      end
      rd_in[k].vld  = a_hit || b_hit || c_hit;
      rd_in[k].addr = (a_hit ? req_a.addr : '0) |
                      (b_hit ? req_b.addr : '0) |
                      (c_last ? crd.addr : '0);
    end

    bhpq_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .lvl         (bhpq_pkg::LW'(k)),
      .ctx         (ctx),
      .tok_in      (tok_in[k]),
      .child_pair  (chi_p),
      .parent_pair (par_p),
      .rd_in       (rd_in[k]),
      .tok_dn      (tok_dn[k]),
      .tok_up      (tok_up[k]),
      .rd_req      (cell_rd[k]),
      .rd_pair     (cell_pair[k]),
      .done        (cell_done[k])
    );
  end

endmodule

`default_nettype wire

@@ hw/rtl/bhpq_checker.sv @@
// ---------------------------------------------------------------------------
// bhpq_checker
// Checks on the result channel of the heap queue, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "binary_heap_priority_queue_assert.svh"

module bhpq_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 out_valid,
  input wire                 out_ready,
  input bhpq_pkg::status_t   out_status,
  input bhpq_pkg::key_t      out_removed_key,
  input bhpq_pkg::cnt_t      out_element_count
);

  // A stalled result word keeps its contents.
  `BHPQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_removed_key) && $stable(out_element_count))

  // A dropped insert can only happen with every slot taken.
  `BHPQ_ASSERT_SAME(a_full_count, out_valid && out_status == bhpq_pkg::ST_FULL, out_element_count == bhpq_pkg::cnt_t'(bhpq_pkg::CAPACITY))

  // An empty remove leaves nothing held and returns a zero key.
  `BHPQ_ASSERT_SAME(a_empty_word, out_valid && out_status == bhpq_pkg::ST_EMPTY, out_element_count == '0 && out_removed_key == '0)

  // The count never exceeds the store size.
  `BHPQ_ASSERT_SAME(a_count_range, out_valid, out_element_count <= bhpq_pkg::cnt_t'(bhpq_pkg::CAPACITY))

endmodule

bind binary_heap_priority_queue bhpq_checker u_bhpq_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_status        (out_chan.status),
  .out_removed_key   (out_chan.removed_key),
  .out_element_count (out_chan.element_count)
);

`default_nettype wire
